// ----- design/b32td_pkg.sv -----
// Package for the Base32 text decoder: character codes, symbol classes and the classifier.
package b32td_pkg;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpO   = 8'h4F;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharUpL   = 8'h4C;
  localparam logic [7:0] CharEight = 8'h38;
  localparam logic [7:0] CharUpB   = 8'h42;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] DigitBase = 8'h32 - 8'd26;
  localparam logic [4:0] Mask5     = 5'h1F;

  typedef enum logic [1:0] {
    SYM_SKIP,
    SYM_DATA,
    SYM_BAD
  } sym_kind_e;

  typedef struct packed {
    sym_kind_e  kind;
    logic [4:0] value;
  } sym_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       message_done;
  } result_t;

  function automatic sym_t classify(input logic [7:0] c_in);
    sym_t       s;
    logic [7:0] c;
    logic [7:0] d;
    s.kind  = SYM_BAD;
    s.value = '0;
    c = c_in;
    if (c == CharZero) begin
      c = CharUpO;
    end else if (c == CharOne) begin
      c = CharUpL;
    end else if (c == CharEight) begin
      c = CharUpB;
    end
    d = c - DigitBase;
    if (c_in == CharSpace || c_in == CharTab || c_in == CharLf || c_in == CharCr ||
        c_in == CharPad) begin
      s.kind = SYM_SKIP;
    end else if ((c >= CharUpA && c <= CharUpZ) || (c >= CharLoA && c <= CharLoZ)) begin
      s.kind  = SYM_DATA;
      s.value = (c[4:0] & Mask5) - 5'd1;
    end else if (c >= CharTwo && c <= CharSeven) begin
      s.kind  = SYM_DATA;
      s.value = d[4:0];
    end
    return s;
  endfunction

endpackage

// ----- design/base32_text_decoder_core.sv -----
// Streaming Base32 text decoder core: input register, decode step and two-entry result buffer.
// One character is accepted per cycle unless the result buffer is full. Each character is captured in
// an input register, then classified and merged into a residue of up to 7 bits once the result
// buffer has room; a result beat (a decoded byte, or the end-of-message status) lands in a two-entry
// output buffer, and throughput is one character per cycle as long as the
// consumer keeps up. White space and '=' are skipped, '0', '1' and '8' are read as 'O', 'L' and
// 'B', and any other non-Base32 character sets bad_char for the rest of the message. Leftover
// bits are dropped at the end-of-message beat, which always yields a result.
module base32_text_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       bad_char_o,
  output logic       message_done_o
);
  import b32td_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eom_q;

  // Decoder state.
  logic [6:0] residue_bits_q, residue_bits_d;
  logic [2:0] residue_count_q, residue_count_d;
  logic       error_q, error_d;

  // Result buffer: head register and skid register.
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    pop, fire;
  logic    push;
  result_t res;
  sym_t    sym;

  logic [11:0] acc;
  logic [3:0]  n_full;
  logic [3:0]  n_left;
  logic [11:0] acc_shift;
  logic [7:0]  mask_wide;
  logic        have_byte;

  assign pop        = out_valid_q & out_ready_i;
  assign fire       = in_valid_q & (~skid_valid_q | pop);
  assign in_ready_o = ~in_valid_q | fire;

  always_comb begin
    sym       = classify(char_q);
    acc       = {residue_bits_q, 5'(sym.value & Mask5)};
    n_full    = {1'b0, residue_count_q} + 4'd5;
    have_byte = 1'b0;
    n_left    = n_full;
    if (n_full >= 4'd8) begin
      have_byte = 1'b1;
      n_left    = n_full - 4'd8;
    end
    acc_shift = acc >> (have_byte ? n_left : 4'd0);
    mask_wide = (8'd1 << n_left[2:0]) - 8'd1;

    residue_bits_d  = residue_bits_q;
    residue_count_d = residue_count_q;
    error_d         = error_q;
    res             = '0;
    if (!error_q) begin
      case (sym.kind)
        SYM_BAD: begin
          error_d = 1'b1;
        end
        SYM_DATA: begin
          residue_count_d = n_left[2:0];
          residue_bits_d  = acc[6:0] & mask_wide[6:0];
          res.byte_valid  = have_byte;
          res.data_byte   = have_byte ? acc_shift[7:0] : 8'h00;
        end
        default: begin
        end
      endcase
    end
    res.bad_char     = error_d;
    res.message_done = eom_q;
    push             = fire & (res.byte_valid | eom_q);
    if (fire && eom_q) begin
      residue_bits_d  = '0;
      residue_count_d = '0;
      error_d         = 1'b0;
    end else if (!fire) begin
      residue_bits_d  = residue_bits_q;
      residue_count_d = residue_count_q;
      error_d         = error_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      residue_bits_q  <= '0;
      residue_count_q <= '0;
      error_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      residue_bits_q  <= residue_bits_d;
      residue_count_q <= residue_count_d;
      error_q         <= error_d;
      if (push) begin
        if (!skid_valid_q && (!out_valid_q || pop)) begin
          out_valid_q <= 1'b1;
        end else if (skid_valid_q && pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
      eom_q  <= end_of_message_i;
    end
    if (push) begin
      if (!skid_valid_q && (!out_valid_q || pop)) begin
        out_q <= res;
      end else if (skid_valid_q && pop) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_q.data_byte;
  assign byte_valid_o   = out_q.byte_valid;
  assign bad_char_o     = out_q.bad_char;
  assign message_done_o = out_q.message_done;

  // The skid entry is only ever filled behind an occupied head.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while head is empty");

  // A decoded byte can only come from a message with no error so far.
  a_byte_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> !bad_char_o)
    else $error("decoded byte reported together with bad_char");

  // A beat without a byte exists only to close a message.
  a_empty_beat_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (message_done_o && data_byte_o == 8'h00))
    else $error("result beat carries neither a byte nor the end marker");

  // The end marker clears all decoder state.
  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eom_q) |=> (residue_count_q == 3'd0 && !error_q && residue_bits_q == 7'd0))
    else $error("decoder state not cleared after end of message");

endmodule

// ----- dv/base32_text_decoder_core_test.sv -----
// Self-checking testbench for the Base32 text decoder core: directed and random messages.
module base32_text_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b32td_pkg::*;

  localparam int unsigned RandomItems = 1400;
  localparam int unsigned CalmItems   = 200;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned DrainCycles = 8;
  localparam longint     TimeoutNs    = 10_000_000;

  // Tracks the decoder's residue and error state and queues the beats it must produce.
  class b32_byte_tracker;
    logic [6:0]  residue;
    int unsigned residue_len;
    bit          saw_bad;
    result_t     awaited_beats[$];
    int unsigned errors;

    function new();
      residue     = '0;
      residue_len = 0;
      saw_bad     = 1'b0;
      errors      = 0;
    endfunction

    function void take_char(logic [7:0] ch, logic eom);
      logic [7:0]  c;
      logic [7:0]  d;
      sym_kind_e   kind;
      logic [4:0]  val;
      logic [11:0] acc;
      logic [11:0] shifted;
      logic [11:0] keep;
      int unsigned n;
      bit          have;
      result_t     r;
      have = 1'b0;
      r    = '0;
      if (!saw_bad) begin
        c    = ch;
        kind = SYM_BAD;
        val  = '0;
        case (ch)
          CharSpace, CharTab, CharLf, CharCr, CharPad: kind = SYM_SKIP;
          CharZero:  c = CharUpO;
          CharOne:   c = CharUpL;
          CharEight: c = CharUpB;
          default: ;
        endcase
        if (kind != SYM_SKIP) begin
          if ((c >= CharUpA && c <= CharUpZ) || (c >= CharLoA && c <= CharLoZ)) begin
            kind = SYM_DATA;
            val  = c[4:0] - 5'd1;
          end else if (c >= CharTwo && c <= CharSeven) begin
            // Digits 2..7 carry the symbol values 26..31.
            kind = SYM_DATA;
            d    = c - DigitBase;
            val  = d[4:0];
          end
        end
        if (kind == SYM_BAD) begin
          saw_bad = 1'b1;
        end else if (kind == SYM_DATA) begin
          acc = {residue, val};
          n   = residue_len + 5;
          if (n >= 8) begin
            shifted     = acc >> (n - 8);
            r.data_byte = shifted[7:0];
            have        = 1'b1;
            n           = n - 8;
          end
          keep        = (12'd1 << n) - 12'd1;
          residue_len = n;
          residue     = 7'(acc & keep);
        end
      end
      if (have || eom) begin
        r.byte_valid   = have;
        r.bad_char     = saw_bad;
        r.message_done = eom;
        awaited_beats.push_back(r);
      end
      if (eom) begin
        residue     = '0;
        residue_len = 0;
        saw_bad     = 1'b0;
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (awaited_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = awaited_beats.pop_front();
      if (got.data_byte !== want.data_byte) report("data_byte", want.data_byte, got.data_byte);
      if (got.byte_valid !== want.byte_valid) begin
        report("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      end
      if (got.bad_char !== want.bad_char) begin
        report("bad_char", 8'(want.bad_char), 8'(got.bad_char));
      end
      if (got.message_done !== want.message_done) begin
        report("message_done", 8'(want.message_done), 8'(got.message_done));
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] char_in_i;
  logic       end_of_message_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       bad_char_o;
  logic       message_done_o;

  b32_byte_tracker tracker = new();
  int unsigned     chars_sent;
  bit              calm;
  bit              hold_done;

  base32_text_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_in_i        (char_in_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .bad_char_o       (bad_char_o),
    .message_done_o   (message_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("base32_text_decoder_core_test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      tracker.take_char(char_in_i, end_of_message_i);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.data_byte    = data_byte_o;
      got.byte_valid   = byte_valid_o;
      got.bad_char     = bad_char_o;
      got.message_done = message_done_o;
      tracker.check_beat(got);
    end
  end

  // Result side: random stall bursts, one long hold-off to back the block up, none at the end.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && chars_sent >= HoldAfter) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_char(logic [7:0] ch, logic eom);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    char_in_i        = ch;
    end_of_message_i = eom;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    chars_sent++;
  endtask

  function automatic logic [7:0] symbol_char();
    logic [7:0] mistyped[3] = '{CharZero, CharOne, CharEight};
    case ($urandom_range(0, 3))
      0: return CharUpA + 8'($urandom_range(0, 25));
      1: return CharLoA + 8'($urandom_range(0, 25));
      2: return CharTwo + 8'($urandom_range(0, 5));
      default: return mistyped[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic logic [7:0] skip_char();
    logic [7:0] skips[5] = '{CharSpace, CharTab, CharLf, CharCr, CharPad};
    return skips[$urandom_range(0, 4)];
  endfunction

  // A message of symbols with some white space; a noisy one carries one random byte.
  task automatic send_message(int unsigned len, bit noisy);
    int unsigned bad_pos;
    logic [7:0]  ch;
    bad_pos = $urandom_range(0, len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      ch = ($urandom_range(0, 9) == 0) ? skip_char() : symbol_char();
      if (noisy && i == bad_pos) ch = 8'($urandom_range(0, 255));
      send_char(ch, i == len - 1);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    char_in_i        = '0;
    end_of_message_i = 1'b0;
    chars_sent       = 0;
    calm             = 1'b0;
    hold_done        = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Letter and digit extremes, the mistyped digits, every skipped character.
    send_char(CharUpA, 1'b0);
    send_char(CharUpZ, 1'b0);
    send_char(CharLoA, 1'b0);
    send_char(CharLoZ, 1'b0);
    send_char(CharTwo, 1'b0);
    send_char(CharSeven, 1'b0);
    send_char(CharZero, 1'b0);
    send_char(CharOne, 1'b0);
    send_char(CharSpace, 1'b0);
    send_char(CharTab, 1'b0);
    send_char(CharLf, 1'b0);
    send_char(CharCr, 1'b0);
    send_char(CharPad, 1'b0);
    send_char(CharEight, 1'b1);
    // A skipped character carrying the end marker.
    send_char(CharPad, 1'b1);
    // 0xA0 is not white space: the rest of the message is ignored.
    send_char(8'hA0, 1'b0);
    send_char(CharUpA, 1'b0);
    send_char(CharUpB, 1'b1);
    // An invalid character that is itself end-marked.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(CharSpace, 1'b1);
    // Error in the middle of a partly filled residue.
    send_char(8'h4D, 1'b0);
    send_char(CharUpZ, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(CharUpA, 1'b1);

    while (chars_sent < 25 + RandomItems) begin
      calm = (chars_sent + CalmItems >= 25 + RandomItems);
      case ($urandom_range(0, 9))
        0: send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1, 2: send_message($urandom_range(1, 20), 1'b1);
        default: send_message($urandom_range(1, 20), 1'b0);
      endcase
    end
    in_valid_i = 1'b0;

    while (tracker.awaited_beats.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (tracker.errors == 0) begin
      $display("base32_text_decoder_core_test passed");
    end else begin
      $display("base32_text_decoder_core_test failed");
    end
    $finish;
  end

endmodule
